// ----- sv/lpps_pkg.sv -----
// Shared types, constants, degree helper and reciprocal tables for the pair-score block.
`default_nettype none

package lpps_pkg;

    localparam int MaxVertices = 1024;
    localparam int MaxEntries  = 8192;
    localparam int MaxDegree   = 256;
    localparam logic [31:0] Ln2Q32 = 32'hB17217F8;

    typedef enum logic [1:0] {
        OP_WR_OFF = 2'd0,
        OP_WR_NB  = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef struct packed {
        op_t         operation;
        logic [12:0] address;
        logic [13:0] write_value;
        logic [9:0]  first_vertex;
        logic [9:0]  second_vertex;
    } in_t;

    typedef struct packed {
        logic [9:0]  vertex_a;
        logic [9:0]  vertex_b;
        logic [16:0] jaccard_score;
        logic [31:0] resource_allocation;
        logic [31:0] adamic_adar;
        logic [16:0] attachment_product;
        logic [16:0] shared_count;
        logic        jaccard_invalid;
        logic        sum_saturated;
        logic        degree_overflow;
    } out_t;

    typedef struct packed {
        logic capture;
        logic wr_off;
        logic wr_nb;
        logic rd_off_a;
        logic lat_a;
        logic lat_b;
        logic rd_nb;
        logic cnt_inc;
        logic rd_off_x;
        logic ld_dx_off;
        logic ld_dx_a;
        logic ld_dx_b;
        logic tbl_rd;
        logic acc_add;
        logic step;
        logic sl_bump;
        logic div_init;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pair_empty;
        logic match;
        logic last_pair;
        logic self_loop;
        logic div_done;
    } ctrl_stat_t;

    typedef struct packed {
        logic       ovf;
        logic [8:0] deg;
    } deg_t;

    typedef logic [16:0] term_tbl_t [0:MaxDegree];

    // degree from a start/end offset pair, clamped to MaxDegree
    function automatic deg_t calc_degree(input logic [13:0] s, input logic [13:0] e);
        deg_t        r;
        logic [13:0] diff;
        diff  = e - s;
        r.ovf = 1'b0;
        r.deg = '0;
        if (e > s) begin
            if (diff > 14'(MaxDegree)) begin
                r.deg = 9'(MaxDegree);
                r.ovf = 1'b1;
            end else begin
                r.deg = diff[8:0];
            end
        end
        return r;
    endfunction

    // shift-subtract quotient, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // floor(2^16 / ln d), ln from log2 by repeated squaring
    function automatic logic [63:0] inv_log_q16(input int unsigned d);
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] lnq;
        int unsigned k;
        k = 0;
        for (int b = 1; b < 32; b++) begin
            if ((d >> b) != 0) k = b;
        end
        m    = 64'(d) << (31 - k);
        frac = '0;
        for (int i = 0; i < 32; i++) begin
            m    = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac[0] = 1'b1;
                m       = m >> 1;
            end
        end
        lnq = 64'(k) * 64'(Ln2Q32) + ((frac * 64'(Ln2Q32)) >> 32);
        return udiv64(64'd1 << 48, lnq);
    endfunction

    function automatic term_tbl_t build_ra_tbl();
        term_tbl_t t;
        for (int d = 0; d <= MaxDegree; d++) begin
            t[d] = (d == 0) ? 17'd0 : 17'(udiv64(64'd65536, 64'(d)));
        end
        return t;
    endfunction

    function automatic term_tbl_t build_aa_tbl();
        term_tbl_t t;
        for (int d = 0; d <= MaxDegree; d++) begin
            t[d] = (d < 2) ? 17'd0 : 17'(inv_log_q16(d));
        end
        return t;
    endfunction

    localparam term_tbl_t RaTbl = build_ra_tbl();
    localparam term_tbl_t AaTbl = build_aa_tbl();

endpackage

`default_nettype wire

// ----- sv/lpps_ctrl.sv -----
// Sequencer for store writes, the pair walk, self-loop terms, divide and output.
`default_nettype none

module lpps_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire lpps_pkg::op_t         operation,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    input  wire lpps_pkg::ctrl_stat_t  stat,
    output lpps_pkg::ctrl_cmd_t        cmd
);
    import lpps_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE = 15'(1) << 0,
        S_RDA  = 15'(1) << 1,
        S_RDB  = 15'(1) << 2,
        S_LATB = 15'(1) << 3,
        S_CHK  = 15'(1) << 4,
        S_NBRD = 15'(1) << 5,
        S_CMP  = 15'(1) << 6,
        S_DEG  = 15'(1) << 7,
        S_TBL  = 15'(1) << 8,
        S_ADD  = 15'(1) << 9,
        S_SLA  = 15'(1) << 10,
        S_SLB  = 15'(1) << 11,
        S_JAC  = 15'(1) << 12,
        S_DIV  = 15'(1) << 13,
        S_FIN  = 15'(1) << 14
    } state_t;

    typedef enum logic [1:0] {
        TERM_PAIR   = 2'd0,
        TERM_SELF_A = 2'd1,
        TERM_SELF_B = 2'd2
    } term_t;

    state_t state_reg, state_next;
    term_t  term_reg, term_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        term_next  = term_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (operation)
                        OP_WR_OFF: cmd.wr_off = 1'b1;
                        OP_WR_NB:  cmd.wr_nb  = 1'b1;
                        OP_QUERY: begin
                            cmd.capture = 1'b1;
                            state_next  = S_RDA;
                        end
                        default: ;
                    endcase
                end
            end
            S_RDA: begin
                cmd.rd_off_a = 1'b1;
                state_next   = S_RDB;
            end
            S_RDB: begin
                cmd.lat_a  = 1'b1;
                state_next = S_LATB;
            end
            S_LATB: begin
                cmd.lat_b  = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                state_next = stat.pair_empty ? S_SLA : S_NBRD;
            end
            S_NBRD: begin
                cmd.rd_nb  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                if (stat.match) begin
                    cmd.cnt_inc  = 1'b1;
                    cmd.rd_off_x = 1'b1;
                    term_next    = TERM_PAIR;
                    state_next   = S_DEG;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = stat.last_pair ? S_SLA : S_NBRD;
                end
            end
            S_DEG: begin
                cmd.ld_dx_off = 1'b1;
                state_next    = S_TBL;
            end
            S_TBL: begin
                cmd.tbl_rd = 1'b1;
                state_next = S_ADD;
            end
            S_ADD: begin
                cmd.acc_add = 1'b1;
                case (term_reg)
                    TERM_PAIR: begin
                        cmd.step   = 1'b1;
                        state_next = stat.last_pair ? S_SLA : S_NBRD;
                    end
                    TERM_SELF_A: state_next = S_SLB;
                    default:     state_next = S_JAC;
                endcase
            end
            S_SLA: begin
                if (stat.self_loop) begin
                    cmd.sl_bump = 1'b1;
                    cmd.ld_dx_a = 1'b1;
                    term_next   = TERM_SELF_A;
                    state_next  = S_TBL;
                end else begin
                    state_next = S_JAC;
                end
            end
            S_SLB: begin
                cmd.ld_dx_b = 1'b1;
                term_next   = TERM_SELF_B;
                state_next  = S_TBL;
            end
            S_JAC: begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
        else              m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            term_reg    <= TERM_PAIR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            term_reg    <= term_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before taken");

    a_add_after_tbl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.acc_add |-> $past(cmd.tbl_rd))
        else $error("accumulate without table read");

    a_query_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && operation == OP_QUERY) |=> (state_reg == S_RDA))
        else $error("query did not start offset read");

    a_div_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && !stat.div_done) |=> (state_reg == S_DIV))
        else $error("divide left early");
`endif

endmodule

`default_nettype wire

// ----- sv/lpps_dp.sv -----
// Datapath: offset and neighbour stores, walk indexes, accumulators, divider, result register.
`default_nettype none

module lpps_dp (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_wdata,
    input  wire lpps_pkg::in_t         s_data,
    input  wire lpps_pkg::ctrl_cmd_t   cmd,
    output lpps_pkg::ctrl_stat_t       stat,
    output lpps_pkg::out_t             m_data
);
    import lpps_pkg::*;

    logic [13:0] off_mem [0:MaxVertices];
    logic [9:0]  nb_mem  [0:MaxEntries-1];

    logic        sl_reg;
    logic [13:0] off_rd0_reg, off_rd1_reg;
    logic [9:0]  nb_rd_a_reg, nb_rd_b_reg;
    logic        nb_oob_a_reg, nb_oob_b_reg;
    logic [9:0]  va_reg, vb_reg;
    logic [13:0] sa_reg, sb_reg;
    logic [8:0]  da_reg, db_reg, dx_reg;
    logic [8:0]  i_reg, j_reg;
    logic [16:0] cnt_reg;
    logic [16:0] ra_term_reg, aa_term_reg;
    logic [31:0] rai_reg, aai_reg;
    logic        rai_ovf_reg, aai_ovf_reg, rai_inf_reg, aai_inf_reg, dovf_reg;
    logic [9:0]  rem_reg;
    logic [16:0] q_reg;
    logic [4:0]  dcnt_reg;
    out_t        out_reg;

    logic [10:0] off_addr0, off_addr1;
    logic [14:0] idx_a, idx_b;
    logic [9:0]  x_val, y_val;
    deg_t        deg_cur;
    logic [32:0] rai_sum, aai_sum;
    logic [9:0]  uni, den;
    logic        jac_inv, jac_sat;
    logic [10:0] rem2;
    logic        qbit;
    logic [8:0]  fa, fb;
    logic [17:0] prod;

    assign x_val   = nb_oob_a_reg ? 10'd0 : nb_rd_a_reg;
    assign y_val   = nb_oob_b_reg ? 10'd0 : nb_rd_b_reg;
    assign deg_cur = calc_degree(off_rd0_reg, off_rd1_reg);

    always_comb begin
        if (cmd.rd_off_x)   off_addr0 = {1'b0, x_val};
        else if (cmd.lat_a) off_addr0 = {1'b0, vb_reg};
        else                off_addr0 = {1'b0, va_reg};
        off_addr1 = off_addr0 + 11'd1;
    end

    assign idx_a = {1'b0, sa_reg} + 15'(i_reg);
    assign idx_b = {1'b0, sb_reg} + 15'(j_reg);

    // stores
    always_ff @(posedge aclk) begin
        if (cmd.wr_off && s_data.address <= 13'(MaxVertices)) begin
            off_mem[s_data.address[10:0]] <= s_data.write_value;
        end
        if (cmd.wr_nb) begin
            nb_mem[s_data.address] <= s_data.write_value[9:0];
        end
        if (cmd.rd_off_a || cmd.lat_a || cmd.rd_off_x) begin
            off_rd0_reg <= off_mem[off_addr0];
            off_rd1_reg <= off_mem[off_addr1];
        end
        if (cmd.rd_nb) begin
            nb_rd_a_reg  <= nb_mem[idx_a[12:0]];
            nb_rd_b_reg  <= nb_mem[idx_b[12:0]];
            nb_oob_a_reg <= (idx_a[14:13] != 2'd0);
            nb_oob_b_reg <= (idx_b[14:13] != 2'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) sl_reg <= 1'b0;
        else if (cfg_we) sl_reg <= cfg_wdata;
    end

    assign rai_sum = {1'b0, rai_reg} + 33'(ra_term_reg);
    assign aai_sum = {1'b0, aai_reg} + 33'(aa_term_reg);

    // walk, degrees and sums
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            va_reg      <= s_data.first_vertex;
            vb_reg      <= s_data.second_vertex;
            rai_reg     <= '0;
            aai_reg     <= '0;
            rai_ovf_reg <= 1'b0;
            aai_ovf_reg <= 1'b0;
            rai_inf_reg <= 1'b0;
            aai_inf_reg <= 1'b0;
            dovf_reg    <= 1'b0;
        end
        if (cmd.lat_a) begin
            sa_reg <= off_rd0_reg;
            da_reg <= deg_cur.deg;
            if (deg_cur.ovf) dovf_reg <= 1'b1;
        end
        if (cmd.lat_b) begin
            sb_reg <= off_rd0_reg;
            db_reg <= deg_cur.deg;
            if (deg_cur.ovf) dovf_reg <= 1'b1;
            i_reg  <= '0;
            j_reg  <= '0;
        end
        if (cmd.ld_dx_off) begin
            dx_reg <= deg_cur.deg;
            if (deg_cur.ovf) dovf_reg <= 1'b1;
        end
        if (cmd.ld_dx_a) dx_reg <= da_reg;
        if (cmd.ld_dx_b) dx_reg <= db_reg;
        if (cmd.tbl_rd) begin
            ra_term_reg <= RaTbl[dx_reg];
            aa_term_reg <= AaTbl[dx_reg];
        end
        if (cmd.acc_add) begin
            // zero-degree entries and the one-degree Adamic-Adar entry read zero; the flags carry them
            rai_reg <= rai_sum[31:0];
            aai_reg <= aai_sum[31:0];
            if (rai_sum[32]) rai_ovf_reg <= 1'b1;
            if (aai_sum[32]) aai_ovf_reg <= 1'b1;
            if (dx_reg == 9'd0) rai_inf_reg <= 1'b1;
            if (dx_reg == 9'd1) aai_inf_reg <= 1'b1;
        end
        if (cmd.step) begin
            if (j_reg == db_reg - 9'd1) begin
                j_reg <= '0;
                i_reg <= i_reg + 9'd1;
            end else begin
                j_reg <= j_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture)      cnt_reg <= '0;
        else if (cmd.cnt_inc) cnt_reg <= cnt_reg + 17'd1;
        else if (cmd.sl_bump) cnt_reg <= cnt_reg + 17'd2;
    end

    // jaccard: quotient bits 16..0, remainder seeded with cnt >> 1
    assign uni     = 10'(da_reg) + 10'(db_reg) + (sl_reg ? 10'd2 : 10'd0);
    assign jac_inv = (cnt_reg >= 17'(uni));
    assign den     = uni - cnt_reg[9:0];
    assign jac_sat = (cnt_reg >= {6'd0, den, 1'b0});
    assign rem2    = {rem_reg, (dcnt_reg == 5'd0) ? cnt_reg[0] : 1'b0};
    assign qbit    = (rem2 >= {1'b0, den});

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg  <= cnt_reg[10:1];
            q_reg    <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= qbit ? 10'(rem2 - {1'b0, den}) : rem2[9:0];
            q_reg    <= {q_reg[15:0], qbit};
            dcnt_reg <= dcnt_reg + 5'd1;
        end
    end

    assign fa   = da_reg + {8'd0, sl_reg};
    assign fb   = db_reg + {8'd0, sl_reg};
    assign prod = fa * fb;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.vertex_a            <= va_reg;
            out_reg.vertex_b            <= vb_reg;
            out_reg.jaccard_score       <= (jac_inv || jac_sat) ? '1 : q_reg;
            out_reg.resource_allocation <= (rai_inf_reg || rai_ovf_reg) ? '1 : rai_reg;
            out_reg.adamic_adar         <= (aai_inf_reg || aai_ovf_reg) ? '1 : aai_reg;
            out_reg.attachment_product  <= prod[16:0];
            out_reg.shared_count        <= cnt_reg;
            out_reg.jaccard_invalid     <= jac_inv;
            out_reg.sum_saturated       <= rai_inf_reg || aai_inf_reg
                                           || rai_ovf_reg || aai_ovf_reg;
            out_reg.degree_overflow     <= dovf_reg;
        end
    end

    assign m_data = out_reg;

    assign stat.pair_empty = (da_reg == 9'd0) || (db_reg == 9'd0);
    assign stat.match      = (x_val == y_val);
    assign stat.last_pair  = (i_reg == da_reg - 9'd1) && (j_reg == db_reg - 9'd1);
    assign stat.self_loop  = sl_reg;
    assign stat.div_done   = (dcnt_reg == 5'd16);

endmodule

`default_nettype wire

// ----- sv/link_prediction_pair_scores.sv -----
// Top level of the link-prediction pair-score block: sequencer plus datapath.
//
// Use: one input channel (s_valid/s_ready/s_data) carries three kinds of beat.
// A write-offset beat stores write_value at offset entry address (0..1024), a
// write-neighbour beat stores the low 10 bits at neighbour entry address; both
// are done in the idle state and give no result. A query beat names two
// vertices and gives one result beat on m_valid/m_ready/m_data.
// A query's time is dominated by the nested walk over neighbour entry pairs
// of the two clamped lists: each pair costs one neighbour-store read and a
// compare; each match adds an offset read, a table read and an accumulate.
// The Jaccard divide is a restoring unit that forms its 17 quotient bits in
// turn. One query is in work at a time; s_ready is high only while the
// sequencer is idle. The result sits in an output register: a stalled
// receiver does not block writes or the next query until that query needs
// the register. Reset clears control and self_loop_mode; stores are
// undefined until written. cfg_we/cfg_wdata write self_loop_mode; the user
// does so only while idle, which the block itself does not enforce.
`default_nettype none

module link_prediction_pair_scores (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_we,
    input  wire logic            cfg_wdata,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire lpps_pkg::in_t   s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output lpps_pkg::out_t       m_data
);
    import lpps_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    lpps_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .operation (s_data.operation),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lpps_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for the link-prediction pair-score block: graph load, queries, self-loop mode.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import lpps_pkg::*;

    // Operation code the block must ignore.
    localparam logic [1:0] OpUnused = 2'd3;
    // Vertex with an empty list at the top of the vertex range.
    localparam int TopVertex = 1023;
    // Vertex whose list is longer than the table bound.
    localparam int WideVertex = 20;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic cfg_wdata;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    link_prediction_pair_scores dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Local copy of the graph; written flags keep every query inside the
    // part of the stores that has been loaded.
    logic [13:0] offset_mem [0:MaxVertices];
    bit          offset_set [0:MaxVertices];
    logic [9:0]  neigh_mem  [0:MaxEntries-1];
    bit          neigh_set  [0:MaxEntries-1];
    bit          self_loop;

    out_t scores_due [$];
    int   errors;
    int   sender_idle_pct;
    int   receiver_stall_pct;
    int   hold_cycles;
    int   queries_sent;
    int   graph_edges;   // neighbour entries in use by vertices 0..15

    // Scratch state for one prediction.
    bit                  reads_ok;
    bit                  deg_ovf;
    bit                  ra_inf;
    bit                  aa_inf;
    longint unsigned     ra_sum;
    longint unsigned     aa_sum;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ---------------- prediction ----------------

    function automatic longint unsigned read_offset(longint unsigned i);
        if (i > MaxVertices) return 0;
        if (!offset_set[i]) reads_ok = 1'b0;
        return offset_mem[i];
    endfunction

    function automatic longint unsigned read_neigh(longint unsigned i);
        if (i >= MaxEntries) return 0;
        if (!neigh_set[i]) reads_ok = 1'b0;
        return neigh_mem[i];
    endfunction

    // Clamped degree; start offset returned through first.
    function automatic longint unsigned list_degree(longint unsigned v,
                                                    output longint unsigned first);
        longint unsigned s;
        longint unsigned e;
        longint unsigned d;
        s = read_offset(v);
        e = read_offset(v + 1);
        d = (e > s) ? e - s : 0;
        if (d > MaxDegree) begin
            d = MaxDegree;
            deg_ovf = 1'b1;
        end
        first = s;
        return d;
    endfunction

    // floor(2^16 / ln d), ln d from a 32-bit fraction of log2 d times ln 2
    function automatic longint unsigned inv_ln_q16(longint unsigned d);
        int              k;
        longint unsigned m;
        longint unsigned frac;
        longint unsigned lnq;
        k = 0;
        while (k < 40 && (d >> (k + 1)) != 0) k++;
        m    = d << (31 - k);
        frac = 0;
        for (int i = 0; i < 32; i++) begin
            m    = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | 1;
                m    = m >> 1;
            end
        end
        lnq = longint'(k) * 64'hB17217F8 + ((frac * 64'hB17217F8) >> 32);
        if (lnq == 0) return 64'hFFFF_FFFF;
        return (64'd1 << 48) / lnq;
    endfunction

    function automatic void add_neighbour_terms(longint unsigned d);
        if (d == 0) begin
            ra_inf = 1'b1;
            return;
        end
        ra_sum += 65536 / d;
        if (d == 1) aa_inf = 1'b1;
        else aa_sum += inv_ln_q16(d);
    endfunction

    // Scores for one vertex pair; reads_ok drops if an unloaded entry is touched.
    function automatic out_t pair_scores(logic [9:0] va, logic [9:0] vb);
        out_t            r;
        longint unsigned sa, sb, da, db, x, dummy, cnt, uni, prod, jac;
        longint          den;
        reads_ok = 1'b1;
        deg_ovf  = 1'b0;
        ra_inf   = 1'b0;
        aa_inf   = 1'b0;
        ra_sum   = 0;
        aa_sum   = 0;
        cnt      = 0;
        da = list_degree(va, sa);
        db = list_degree(vb, sb);
        for (longint unsigned i = 0; i < da; i++) begin
            x = read_neigh(sa + i);
            for (longint unsigned j = 0; j < db; j++) begin
                if (x == read_neigh(sb + j)) begin
                    cnt++;
                    add_neighbour_terms(list_degree(x, dummy));
                end
            end
        end
        uni = da + db;
        if (self_loop) begin
            cnt += 2;
            uni += 2;
            add_neighbour_terms(da);
            add_neighbour_terms(db);
            prod = (da + 1) * (db + 1);
        end else begin
            prod = da * db;
        end
        den = longint'(uni) - longint'(cnt);
        r.jaccard_invalid = (den <= 0);
        if (den <= 0) begin
            jac = 131071;
        end else begin
            jac = (cnt << 16) / longint'(den);
            if (jac > 131071) jac = 131071;
        end
        r.vertex_a            = va;
        r.vertex_b            = vb;
        r.jaccard_score       = jac[16:0];
        r.sum_saturated       = ra_inf || aa_inf || ra_sum > 64'hFFFF_FFFF
                                || aa_sum > 64'hFFFF_FFFF;
        r.resource_allocation = (ra_inf || ra_sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                   : ra_sum[31:0];
        r.adamic_adar         = (aa_inf || aa_sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                   : aa_sum[31:0];
        r.attachment_product  = (prod > 131071) ? 17'h1FFFF : prod[16:0];
        r.shared_count        = (cnt > 131071) ? 17'h1FFFF : cnt[16:0];
        r.degree_overflow     = deg_ovf;
        return r;
    endfunction

    // ---------------- driving ----------------

    // Send one beat; the local graph and the expected scores follow the
    // beat at the edge where it is accepted.
    task automatic send_beat(in_t item);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        case (item.operation)
            OP_WR_OFF: begin
                if (item.address <= MaxVertices) begin
                    offset_mem[item.address] = item.write_value;
                    offset_set[item.address] = 1'b1;
                end
            end
            OP_WR_NB: begin
                neigh_mem[item.address] = item.write_value[9:0];
                neigh_set[item.address] = 1'b1;
            end
            OP_QUERY: begin
                scores_due.push_back(pair_scores(item.first_vertex, item.second_vertex));
                queries_sent++;
            end
            default: ;
        endcase
    endtask

    // Write/noise beat with all unused fields random.
    function automatic in_t noise_beat(logic [1:0] op, int addr, int value);
        in_t b;
        b.operation     = op_t'(op);
        b.address       = 13'(addr);
        b.write_value   = 14'(value);
        b.first_vertex  = 10'($urandom);
        b.second_vertex = 10'($urandom);
        return b;
    endfunction

    task automatic send_query(int va, int vb);
        in_t b;
        b = noise_beat(OP_QUERY, $urandom_range(8191), $urandom_range(16383));
        b.first_vertex  = 10'(va);
        b.second_vertex = 10'(vb);
        send_beat(b);
    endtask

    task automatic send_write(op_t op, int addr, int value);
        send_beat(noise_beat(op, addr, value));
    endtask

    // Drains outstanding results, waits out any write still settling, then
    // sets self-loop mode while the block is idle.
    task automatic set_self_loop(bit mode);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (scores_due.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        self_loop = mode;
    endtask

    // ---------------- result side ----------------

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (scores_due.size() == 0) begin
                $error("result beat with no query outstanding");
                errors++;
            end else begin
                out_t e;
                e = scores_due.pop_front();
                check_field("vertex_a", e.vertex_a, m_data.vertex_a);
                check_field("vertex_b", e.vertex_b, m_data.vertex_b);
                check_field("jaccard_score", e.jaccard_score, m_data.jaccard_score);
                check_field("resource_allocation", e.resource_allocation,
                            m_data.resource_allocation);
                check_field("adamic_adar", e.adamic_adar, m_data.adamic_adar);
                check_field("attachment_product", e.attachment_product,
                            m_data.attachment_product);
                check_field("shared_count", e.shared_count, m_data.shared_count);
                check_field("jaccard_invalid", e.jaccard_invalid, m_data.jaccard_invalid);
                check_field("sum_saturated", e.sum_saturated, m_data.sum_saturated);
                check_field("degree_overflow", e.degree_overflow, m_data.degree_overflow);
            end
        end
    end

    // ---------------- tests ----------------

    // Small graph on vertices 0..15: random short lists, a one-entry list
    // (vertex 14), descending offsets (vertex 15), an empty list at the top
    // vertex and an over-long list whose entries are never walked.
    task automatic test_load_graph();
        int ofs;
        ofs = 0;
        for (int v = 0; v < 14; v++) begin
            send_write(OP_WR_OFF, v, ofs);
            ofs += $urandom_range(5);
        end
        send_write(OP_WR_OFF, 14, ofs);
        send_write(OP_WR_OFF, 15, ofs + 1);
        send_write(OP_WR_OFF, 16, ofs);
        graph_edges = ofs + 1;
        for (int i = 0; i < graph_edges; i++)
            send_write(OP_WR_NB, i, ($urandom_range(3) == 0) ? $urandom_range(15)
                                                             : $urandom_range(7));
        send_write(OP_WR_OFF, TopVertex, 100);
        send_write(OP_WR_OFF, TopVertex + 1, 100);
        send_write(OP_WR_OFF, WideVertex, 7000);
        send_write(OP_WR_OFF, WideVertex + 1, 7300);
        // ignored: offset address past the store, unused operation
        send_write(OP_WR_OFF, 8191, 16383);
        send_beat(noise_beat(OpUnused, $urandom_range(8191), $urandom_range(16383)));
    endtask

    // A plain pair, self pair, empty lists, clamped degree, one-entry list.
    task automatic test_directed_queries();
        send_query(0, 1);
        send_query(3, 3);
        send_query(14, 2);
        send_query(15, 4);
        send_query(TopVertex, TopVertex);
        send_query(TopVertex, WideVertex);
        send_query(5, 14);
        send_query(7, 6);
    endtask

    // A mix dominated by queries on the loaded graph; rewrites keep the
    // neighbour ids inside vertices 0..15 so later queries stay well formed.
    task automatic test_random_traffic(int count);
        for (int n = 0; n < count; n++) begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 65) begin
                int va, vb;
                out_t probe;
                va = ($urandom_range(19) == 0) ? TopVertex : $urandom_range(15);
                vb = ($urandom_range(19) == 0) ? WideVertex : $urandom_range(15);
                probe = pair_scores(10'(va), 10'(vb));
                if (!reads_ok) begin
                    va = TopVertex;
                    vb = WideVertex;
                end
                send_query(va, vb);
            end else if (pick < 80) begin
                send_write(OP_WR_NB, $urandom_range(graph_edges - 1), $urandom_range(15));
            end else if (pick < 85) begin
                // high neighbour entries, never walked
                send_write(OP_WR_NB, $urandom_range(8191, 7400), $urandom_range(16383));
            end else if (pick < 92) begin
                send_write(OP_WR_OFF, $urandom_range(13, 1), $urandom_range(graph_edges - 1));
            end else if (pick < 96) begin
                send_write(OP_WR_OFF, $urandom_range(8191, MaxVertices + 1),
                           $urandom_range(16383));
            end else begin
                send_beat(noise_beat(OpUnused, $urandom_range(8191), $urandom_range(16383)));
            end
        end
    endtask

    // Receiver holds off for a long stretch while queries keep coming, so the
    // output register fills and s_ready stays low.
    task automatic test_result_backpressure();
        hold_cycles = 2000;
        for (int n = 0; n < 6; n++) send_query($urandom_range(13), $urandom_range(13));
    endtask

    initial begin
        errors             = 0;
        queries_sent       = 0;
        hold_cycles        = 0;
        sender_idle_pct    = 8;
        receiver_stall_pct = 53;
        self_loop          = 1'b0;
        aresetn            = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = 1'b0;
        s_valid            = 1'b0;
        s_data             = '0;
        for (int i = 0; i <= MaxVertices; i++) offset_set[i] = 1'b0;
        for (int i = 0; i < MaxEntries; i++) neigh_set[i] = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        test_load_graph();
        test_directed_queries();
        set_self_loop(1'b1);
        test_directed_queries();
        set_self_loop(1'b0);

        test_random_traffic(20);
        set_self_loop(1'b1);
        sender_idle_pct    = 53;
        receiver_stall_pct = 8;
        test_random_traffic(20);
        test_result_backpressure();
        set_self_loop(1'b0);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        test_random_traffic(20);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (scores_due.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Covered %0d queries over a small loaded graph, both self-loop settings,",
                 queries_sent);
        $display("empty, one-entry, descending and clamped lists, and a long result stall.");
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
